/* rtl/rfsdq_pkg.sv */
// Shared types, codes and pointer helpers for the thread scheduler.
// No dependencies; every other file of the block imports this package.
package rfsdq_pkg;

  localparam int MAX_THREADS = 64;
  localparam int PTR_W       = $clog2(MAX_THREADS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);
  localparam int ID_W        = 6;
  localparam int AMT_W       = 16;
  localparam int SLICE_W     = 10;
  localparam int DELTA_W     = AMT_W + 1;
  localparam int STEP_W      = $clog2(AMT_W + 1);

  localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(2);

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_GET   = 2'd1,
    MODE_SLEEP = 2'd2,
    MODE_TICK  = 2'd3
  } mode_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // One sleep list entry: thread and its wake time relative to the entry before
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [DELTA_W-1:0] delta;
  } sleep_ent_t;

  // Rounding unit result
  typedef struct packed {
    logic               done;
    logic [DELTA_W-1:0] t;
  } round_res_t;

  // Circular buffer pointer arithmetic
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] base,
                                               input logic [PTR_W-1:0] off);
    logic [PTR_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (PTR_W+1)'(MAX_THREADS)) begin
      s = s - (PTR_W+1)'(MAX_THREADS);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

/* rtl/rfsdq_round.sv */
// Iterative round-up of a sleep time to a multiple of the time slice.
// Restoring remainder, one bit a cycle; depends on rfsdq_pkg.
module rfsdq_round (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rfsdq_pkg::AMT_W-1:0]    amount,
  input  logic [rfsdq_pkg::SLICE_W-1:0]  slice,
  output rfsdq_pkg::round_res_t          res
);
  import rfsdq_pkg::*;

  logic                busy;
  logic [STEP_W-1:0]   cnt;
  logic [AMT_W-1:0]    amt_keep;
  logic [AMT_W-1:0]    amt_sh;
  logic [SLICE_W-1:0]  slc;
  logic [SLICE_W-1:0]  rem;
  logic [SLICE_W:0]    sh;
  logic [SLICE_W-1:0]  pad;

  // Shift in the next dividend bit
  assign sh  = {rem, amt_sh[AMT_W-1]};
  assign pad = (rem != '0) ? (slc - rem) : '0;

  // Step the remainder, then add the padding up to the next multiple
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      res.done <= 1'b0;
    end else begin
      res.done <= !start && busy && (cnt == '0);
      if (start) begin
        busy     <= 1'b1;
        cnt      <= STEP_W'(AMT_W);
        amt_keep <= amount;
        amt_sh   <= amount;
        slc      <= (slice == '0) ? SLICE_W'(1) : slice;
        rem      <= '0;
      end else if (busy) begin
        if (cnt != '0) begin
          if (sh >= {1'b0, slc}) begin
            rem <= SLICE_W'(sh - {1'b0, slc});
          end else begin
            rem <= sh[SLICE_W-1:0];
          end
          amt_sh <= {amt_sh[AMT_W-2:0], 1'b0};
          cnt    <= cnt - STEP_W'(1);
        end else begin
          busy  <= 1'b0;
          res.t <= {1'b0, amt_keep} + DELTA_W'(pad);
        end
      end
    end
  end

endmodule

/* rtl/ready_fifo_with_sleep_delta_queue.sv */
// Thread scheduler: FIFO ready queue and delta-ordered sleep list in memory.
// Depends on rfsdq_pkg and rfsdq_round.
// Usage:
//   Item channel (item_valid/item_stall): mode, thread_id, amount. A word is
//   taken when item_valid is high and item_stall low; the block takes one
//   item at a time and holds item_stall high while it works on it.
//   Result channel (result_valid/result_stall): exactly one result word per
//   item, held in an output register until the receiver lowers result_stall.
//   The next item is accepted while that word still waits.
//   Config channel (cfg_valid/cfg_ready/cfg_data): writes time_slice; always
//   ready; write it only while the block is idle (the block does not enforce it).
// Sequence after the accepting edge: decode (S_DEC), then the result step (S_FIN)
// for put and for an empty get, a tick with no sleepers or a sleep that is
// ignored or dropped; S_GET or S_TICK comes between for other gets and ticks;
// for an inserted sleep the 16-step round-up unit runs first, then a read and an
// evaluate state per entry up to the tail, as later sleepers shift back.
// The block is idle again from the edge that raises result_valid.
// A stalled receiver only delays the last step; the state is updated already.
// Reset (rst, synchronous) empties both queues and sets time_slice to 2;
// memory contents are not cleared, only the counts, so no clearing pass.
module ready_fifo_with_sleep_delta_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [1:0]                     mode,
  input  logic [rfsdq_pkg::ID_W-1:0]     thread_id,
  input  logic [rfsdq_pkg::AMT_W-1:0]    amount,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [rfsdq_pkg::ID_W-1:0]     out_thread,
  output logic                           out_valid,
  output logic [1:0]                     status,
  output logic                           woke,
  output logic                           has_threads,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rfsdq_pkg::SLICE_W-1:0]  cfg_data
);
  import rfsdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_GET,
    S_TICK,
    S_SWAIT,
    S_SRD,
    S_SEV,
    S_FIN
  } state_t;

  state_t               state;
  logic [SLICE_W-1:0]   time_slice;
  mode_t                itm_mode;
  logic [ID_W-1:0]      itm_id;
  logic [AMT_W-1:0]     itm_amount;

  logic [PTR_W-1:0]     ready_head;
  logic [CNT_W-1:0]     ready_count;
  logic [PTR_W-1:0]     sleep_head;
  logic [CNT_W-1:0]     sleep_count;
  logic [CNT_W-1:0]     idx;
  logic [DELTA_W-1:0]   t_acc;
  logic                 placed;
  sleep_ent_t           carry;

  logic [ID_W-1:0]      r_thread;
  logic                 r_valid;
  logic [1:0]           r_status;
  logic                 r_woke;

  // Memories
  logic [ID_W-1:0]      ready_mem [MAX_THREADS];
  logic [ID_W-1:0]      ready_rdata;
  logic                 ready_we;
  logic [PTR_W-1:0]     ready_tail;
  logic [ID_W-1:0]      ready_wdata;

  sleep_ent_t           sleep_mem [MAX_THREADS];
  sleep_ent_t           sleep_rdata;
  logic                 sleep_we;
  logic [PTR_W-1:0]     sleep_addr;
  sleep_ent_t           sleep_wdata;

  logic                 ready_room;
  logic                 sleep_room;
  logic                 expire;
  logic                 fits;
  logic                 out_free;
  logic                 round_start;
  round_res_t           round_res;

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || !result_stall;

  assign ready_room = (ready_count < CNT_W'(MAX_THREADS));
  assign sleep_room = (sleep_count < CNT_W'(MAX_THREADS));
  assign ready_tail = ptr_add(ready_head, ready_count[PTR_W-1:0]);
  assign sleep_addr = ptr_add(sleep_head, idx[PTR_W-1:0]);

  // Head sleeper is due, and the new sleeper goes after the entry read
  assign expire = (sleep_rdata.delta <= {1'b0, itm_amount});
  assign fits   = (sleep_rdata.delta <= t_acc);

  assign round_start = (state == S_DEC) && (itm_mode == MODE_SLEEP) &&
                       (itm_amount != '0) && sleep_room;

  rfsdq_round u_round (
    .clk    (clk),
    .rst    (rst),
    .start  (round_start),
    .amount (itm_amount),
    .slice  (time_slice),
    .res    (round_res)
  );

  // Ready queue write: put at decode, or a woken sleeper at tick
  always_comb begin
    ready_we    = ((state == S_DEC) && (itm_mode == MODE_PUT) && ready_room) ||
                  ((state == S_TICK) && expire && ready_room);
    ready_wdata = (state == S_TICK) ? sleep_rdata.id : itm_id;
  end

  // Sleep list write: head delta update at tick, or one step of the insert walk
  always_comb begin
    sleep_we    = 1'b0;
    sleep_wdata = placed ? carry : sleep_ent_t'{id: itm_id, delta: t_acc};
    case (state)
      S_TICK: begin
        sleep_we    = !expire;
        sleep_wdata = sleep_ent_t'{id: sleep_rdata.id,
                                   delta: sleep_rdata.delta - {1'b0, itm_amount}};
      end
      S_SRD: sleep_we = (idx == sleep_count);
      S_SEV: sleep_we = placed || !fits;
      default: sleep_we = 1'b0;
    endcase
  end

  // Ready memory: read the head every cycle
  always_ff @(posedge clk) begin
    if (ready_we) begin
      ready_mem[ready_tail] <= ready_wdata;
    end
    ready_rdata <= ready_mem[ready_head];
  end

  // Sleep memory: read and write at the walk position
  always_ff @(posedge clk) begin
    if (sleep_we) begin
      sleep_mem[sleep_addr] <= sleep_wdata;
    end
    sleep_rdata <= sleep_mem[sleep_addr];
  end

  // Sequencer, queue state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      time_slice   <= SLICE_RESET;
      result_valid <= 1'b0;
      ready_head   <= '0;
      ready_count  <= '0;
      sleep_head   <= '0;
      sleep_count  <= '0;
      idx          <= '0;
      placed       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        time_slice <= cfg_data;
      end
      // Drop a taken word unless a new one replaces it this cycle
      if (result_valid && !result_stall && (state != S_FIN)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            itm_mode   <= mode_t'(mode);
            itm_id     <= thread_id;
            itm_amount <= amount;
            r_thread   <= '0;
            r_valid    <= 1'b0;
            r_status   <= STATUS_OK;
            r_woke     <= 1'b0;
            idx        <= '0;
            state      <= S_DEC;
          end
        end
        S_DEC: begin
          case (itm_mode)
            MODE_PUT: begin
              if (ready_room) begin
                ready_count <= ready_count + CNT_W'(1);
              end else begin
                r_status <= STATUS_FULL;
              end
              state <= S_FIN;
            end
            MODE_GET: begin
              if (ready_count == '0) begin
                r_status <= STATUS_EMPTY;
                state    <= S_FIN;
              end else begin
                state <= S_GET;
              end
            end
            MODE_SLEEP: begin
              if (itm_amount == '0) begin
                state <= S_FIN;
              end else if (!sleep_room) begin
                r_status <= STATUS_FULL;
                state    <= S_FIN;
              end else begin
                state <= S_SWAIT;
              end
            end
            MODE_TICK: begin
              state <= (sleep_count == '0) ? S_FIN : S_TICK;
            end
            default: state <= S_FIN;
          endcase
        end
        S_GET: begin
          r_thread    <= ready_rdata;
          r_valid     <= 1'b1;
          ready_head  <= ptr_add(ready_head, PTR_W'(1));
          ready_count <= ready_count - CNT_W'(1);
          state       <= S_FIN;
        end
        S_TICK: begin
          // Pop a due sleeper; drop it if the ready queue has no room
          if (expire) begin
            sleep_head  <= ptr_add(sleep_head, PTR_W'(1));
            sleep_count <= sleep_count - CNT_W'(1);
            r_thread    <= sleep_rdata.id;
            r_valid     <= 1'b1;
            if (ready_room) begin
              ready_count <= ready_count + CNT_W'(1);
              r_woke      <= 1'b1;
            end else begin
              r_status <= STATUS_FULL;
            end
          end
          state <= S_FIN;
        end
        S_SWAIT: begin
          if (round_res.done) begin
            t_acc  <= round_res.t;
            placed <= 1'b0;
            state  <= S_SRD;
          end
        end
        S_SRD: begin
          // Past the tail: the final entry is written this cycle
          if (idx == sleep_count) begin
            sleep_count <= sleep_count + CNT_W'(1);
            state       <= S_FIN;
          end else begin
            state <= S_SEV;
          end
        end
        S_SEV: begin
          // Walk past earlier sleepers, then ripple the rest one place back
          if (!placed) begin
            if (fits) begin
              t_acc <= t_acc - sleep_rdata.delta;
            end else begin
              placed <= 1'b1;
              carry  <= sleep_ent_t'{id: sleep_rdata.id,
                                     delta: sleep_rdata.delta - t_acc};
            end
          end else begin
            carry <= sleep_rdata;
          end
          idx   <= idx + CNT_W'(1);
          state <= S_SRD;
        end
        S_FIN: begin
          if (out_free) begin
            out_thread   <= r_thread;
            out_valid    <= r_valid;
            status       <= r_status;
            woke         <= r_woke;
            has_threads  <= (ready_count != '0) || (sleep_count != '0);
            result_valid <= 1'b1;
            idx          <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/rfsdq_check.sv */
// Port-level checks for the thread scheduler, bound to the top level.
// Depends on rfsdq_pkg and ready_fifo_with_sleep_delta_queue.
module rfsdq_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           item_valid,
  input logic                           item_stall,
  input logic                           result_valid,
  input logic                           result_stall,
  input logic [rfsdq_pkg::ID_W-1:0]     out_thread,
  input logic                           out_valid,
  input logic [1:0]                     status,
  input logic                           woke,
  input logic                           has_threads
);
  import rfsdq_pkg::*;

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result pending after reset");

  // One item at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item accepted while previous still in work");

  // An empty get carries no thread
  a_empty_no_thread: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == STATUS_EMPTY |-> !out_valid && out_thread == '0)
    else $error("empty result carries a thread");

  // A wake-up moved a thread into the ready queue
  a_woke_consistent: assert property (@(posedge clk) disable iff (rst)
    result_valid && woke |-> out_valid && status == STATUS_OK && has_threads)
    else $error("woke result inconsistent");

  // Stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(out_thread) &&
                                     $stable(status))
    else $error("stalled result changed");

endmodule

bind ready_fifo_with_sleep_delta_queue rfsdq_check u_rfsdq_check (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .out_thread   (out_thread),
  .out_valid    (out_valid),
  .status       (status),
  .woke         (woke),
  .has_threads  (has_threads)
);
